>>> src/tone_band_detector_unit_assert.svh
// Assertion macros used by the detector RTL.
// TBD_ASSERT_IMPL checks a same-cycle implication, TBD_ASSERT_NEXT a next-cycle one.
`ifndef TONE_BAND_DETECTOR_UNIT_ASSERT_SVH
`define TONE_BAND_DETECTOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TBD_ASSERT_IMPL(LBL, CLK, RSTN, A, C, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |-> (C)) else $error(MSG);
`define TBD_ASSERT_NEXT(LBL, CLK, RSTN, A, C, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |=> (C)) else $error(MSG);
`else
`define TBD_ASSERT_IMPL(LBL, CLK, RSTN, A, C, MSG)
`define TBD_ASSERT_NEXT(LBL, CLK, RSTN, A, C, MSG)
`endif
`endif

>>> src/tbd_pkg.sv
package tbd_pkg;

  // field widths
  localparam int RATE_W  = 24;
  localparam int FREQ_W  = 16;
  localparam int PCT_W   = 7;
  localparam int TOUT_W  = 16;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = FREQ_W + PCT_W;

  localparam int DEFAULT_PERIOD_BITS = 16;

  // band width is a percentage
  localparam int BAND_DIVISOR = 100;

  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TICK_RATE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_TARGET     = 3'd1;
  localparam logic [IDX_W-1:0] REG_BAND_PCT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_FREQ   = 3'd3;
  localparam logic [IDX_W-1:0] REG_TIMEOUT    = 3'd4;

  // reset values
  localparam logic [RATE_W-1:0] RST_TICK_RATE = 24'd1000000;
  localparam logic [FREQ_W-1:0] RST_TARGET    = 16'd1000;
  localparam logic [PCT_W-1:0]  RST_BAND_PCT  = 7'd10;
  localparam logic [FREQ_W-1:0] RST_MIN_FREQ  = 16'd100;
  localparam logic [TOUT_W-1:0] RST_TIMEOUT   = 16'd64256;

  typedef struct packed {
    logic [RATE_W-1:0] tick_rate_hz;
    logic [FREQ_W-1:0] target_freq;
    logic [PCT_W-1:0]  band_percent;
    logic [FREQ_W-1:0] min_freq;
    logic [TOUT_W-1:0] timeout_ticks;
  } tbd_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_BAND,
    ST_DECIDE,
    ST_PUSH
  } tbd_state_t;

endpackage

>>> src/tbd_cfg_regs.sv
module tbd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbd_pkg::IDX_W-1:0]           cfg_index,
  input  logic [tbd_pkg::RATE_W-1:0]          cfg_wdata,
  output tbd_pkg::tbd_cfg_t                   cfg
);

  tbd_pkg::tbd_cfg_t cfg_r;

  // writes are always accepted
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_rate_hz   <= tbd_pkg::RST_TICK_RATE;
      cfg_r.target_freq    <= tbd_pkg::RST_TARGET;
      cfg_r.band_percent   <= tbd_pkg::RST_BAND_PCT;
      cfg_r.min_freq       <= tbd_pkg::RST_MIN_FREQ;
      cfg_r.timeout_ticks  <= tbd_pkg::RST_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbd_pkg::REG_TICK_RATE: cfg_r.tick_rate_hz <= cfg_wdata;
        tbd_pkg::REG_TARGET:    cfg_r.target_freq  <= cfg_wdata[tbd_pkg::FREQ_W-1:0];
        tbd_pkg::REG_BAND_PCT:  cfg_r.band_percent <= cfg_wdata[tbd_pkg::PCT_W-1:0];
        tbd_pkg::REG_MIN_FREQ:  cfg_r.min_freq     <= cfg_wdata[tbd_pkg::FREQ_W-1:0];
        tbd_pkg::REG_TIMEOUT:   cfg_r.timeout_ticks  <= cfg_wdata[tbd_pkg::TOUT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/tbd_serdiv.sv
module tbd_serdiv #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  // dividend bits leave at the top while quotient bits enter at the bottom
  logic [DIVIDEND_W-1:0] shf_r;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // one restoring step per cycle
  always_comb begin
    trial = {rem_r, shf_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = trial >= {1'b0, dvs_r};
  end

  assign busy     = (cnt_r != '0);
  assign quotient = shf_r;

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      shf_r <= dividend;
    end else if (busy) begin
      rem_r <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      shf_r <= {shf_r[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

>>> src/tone_band_detector_unit.sv
// Channel  Direction  Handshake            Payload
// in_      into block in_valid / in_stall  in_level
// out_     from block out_valid / out_stall out_tone_present, out_measured_freq,
//                                           out_freq_updated
// cfg_     into block cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// An item without a rising edge goes from acceptance straight to the push state.
// An item with a rising edge first runs the bit-serial divide of the
// 24-bit tick rate by the period, then band limits, compare and output load.
// One item is worked on at a time; in_stall is high from acceptance until its
// result has entered the output register, which then waits for out_stall to drop.
// Reset is synchronous and active low; there is no clearing pass.
`include "tone_band_detector_unit_assert.svh"

module tone_band_detector_unit #(
  parameter int PERIOD_BITS = tbd_pkg::DEFAULT_PERIOD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_tone_present,
  output logic [tbd_pkg::FREQ_W-1:0]  out_measured_freq,
  output logic                        out_freq_updated,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tbd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tbd_pkg::RATE_W-1:0]  cfg_wdata
);

  localparam int CMP_W = (PERIOD_BITS > tbd_pkg::TOUT_W) ? PERIOD_BITS : tbd_pkg::TOUT_W;
  localparam int BQ_W  = tbd_pkg::PROD_W;
  localparam int BD_W  = $clog2(tbd_pkg::BAND_DIVISOR + 1);

  tbd_pkg::tbd_cfg_t   cfg;
  tbd_pkg::tbd_state_t state_r, state_nxt;

  // measurement state
  logic                       prev_level_r;
  logic [PERIOD_BITS-1:0]     elapsed_r;
  logic                       tone_flag_r;
  logic [tbd_pkg::FREQ_W-1:0] last_freq_r;
  logic                       upd_r;

  // band and frequency stage
  logic [tbd_pkg::FREQ_W-1:0] fsat_r;
  logic [tbd_pkg::FREQ_W-1:0] lo_r;
  logic [tbd_pkg::FREQ_W-1:0] hi_r;

  // output register
  logic                       out_valid_r;
  logic                       out_tone_r;
  logic [tbd_pkg::FREQ_W-1:0] out_freq_r;
  logic                       out_upd_r;

  logic                       accept;
  logic                       edge_det;
  logic [PERIOD_BITS-1:0]     count_inc;
  logic                       timeout_hit;
  logic                       out_free;
  logic                       div_start;
  logic                       load_out;

  logic                       main_busy;
  logic                       band_busy;
  logic [tbd_pkg::RATE_W-1:0] main_q;
  logic [BQ_W-1:0]            band_q;
  logic [tbd_pkg::PROD_W-1:0] band_prod;

  logic [tbd_pkg::FREQ_W-1:0] half;
  logic [tbd_pkg::FREQ_W:0]   hi_sum;

  tbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // tick rate / period
  tbd_serdiv #(
    .DIVIDEND_W (tbd_pkg::RATE_W),
    .DIVISOR_W  (PERIOD_BITS)
  ) u_div_freq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cfg.tick_rate_hz),
    .divisor  (count_inc),
    .busy     (main_busy),
    .quotient (main_q)
  );

  // target * percent / 100
  assign band_prod = tbd_pkg::PROD_W'(cfg.target_freq) * tbd_pkg::PROD_W'(cfg.band_percent);

  tbd_serdiv #(
    .DIVIDEND_W (BQ_W),
    .DIVISOR_W  (BD_W)
  ) u_div_band (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (band_prod),
    .divisor  (BD_W'(tbd_pkg::BAND_DIVISOR)),
    .busy     (band_busy),
    .quotient (band_q)
  );

  // tick decode
  assign accept      = in_valid && !in_stall;
  assign edge_det    = in_level && !prev_level_r;
  assign count_inc   = (elapsed_r == '1) ? elapsed_r : elapsed_r + PERIOD_BITS'(1);
  assign timeout_hit = CMP_W'(count_inc) >= CMP_W'(cfg.timeout_ticks);
  assign out_free    = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbd_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = edge_det ? tbd_pkg::ST_DIVIDE : tbd_pkg::ST_PUSH;
        end
      end
      tbd_pkg::ST_DIVIDE: begin
        if (!main_busy && !band_busy) begin
          state_nxt = tbd_pkg::ST_BAND;
        end
      end
      tbd_pkg::ST_BAND:   state_nxt = tbd_pkg::ST_DECIDE;
      tbd_pkg::ST_DECIDE: state_nxt = tbd_pkg::ST_PUSH;
      tbd_pkg::ST_PUSH: begin
        if (out_free) begin
          state_nxt = tbd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tbd_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = (state_r != tbd_pkg::ST_IDLE);
    div_start = accept && edge_det;
    load_out  = (state_r == tbd_pkg::ST_PUSH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // band limits, clamped to the frequency range
  always_comb begin
    half   = band_q[tbd_pkg::FREQ_W:1];
    hi_sum = {1'b0, cfg.target_freq} + {1'b0, half};
  end

  always_ff @(posedge clk) begin
    if (state_r == tbd_pkg::ST_BAND) begin
      fsat_r <= (main_q[tbd_pkg::RATE_W-1:tbd_pkg::FREQ_W] != '0) ? tbd_pkg::FREQ_MAX
                                                                 : main_q[tbd_pkg::FREQ_W-1:0];
      lo_r   <= (cfg.target_freq > half) ? cfg.target_freq - half : '0;
      hi_r   <= hi_sum[tbd_pkg::FREQ_W] ? tbd_pkg::FREQ_MAX : hi_sum[tbd_pkg::FREQ_W-1:0];
    end
  end

  // measurement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      elapsed_r    <= '0;
      tone_flag_r  <= 1'b0;
      last_freq_r  <= '0;
      upd_r        <= 1'b0;
    end else if (accept) begin
      prev_level_r <= in_level;
      upd_r        <= edge_det;
      if (edge_det) begin
        elapsed_r <= '0;
      end else begin
        elapsed_r <= count_inc;
        if (timeout_hit) begin
          tone_flag_r <= 1'b0;
        end
      end
    end else if (state_r == tbd_pkg::ST_DECIDE) begin
      last_freq_r <= fsat_r;
      tone_flag_r <= (fsat_r >= cfg.min_freq) && (fsat_r >= lo_r) && (fsat_r <= hi_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tone_r <= tone_flag_r;
      out_freq_r <= last_freq_r;
      out_upd_r  <= upd_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tone_present  = out_tone_r;
  assign out_measured_freq = out_freq_r;
  assign out_freq_updated  = out_upd_r;

  // checks
  `TBD_ASSERT_NEXT(a_edge_starts_div, clk, rst_n, accept && edge_det, state_r == tbd_pkg::ST_DIVIDE, "edge item did not start divide")
  `TBD_ASSERT_NEXT(a_edge_clears_cnt, clk, rst_n, accept && edge_det, elapsed_r == '0, "period count not cleared on edge")
  `TBD_ASSERT_IMPL(a_band_after_div, clk, rst_n, state_r == tbd_pkg::ST_BAND, !main_busy && !band_busy, "dividers still busy at band stage")
  `TBD_ASSERT_IMPL(a_tone_rise_src, clk, rst_n, $rose(tone_flag_r), $past(state_r) == tbd_pkg::ST_DECIDE, "tone flag rose outside decide")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int PERIOD_BITS = tbd_pkg::DEFAULT_PERIOD_BITS;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_TICKS = 110;
  localparam logic [tbd_pkg::IDX_W-1:0] REG_LAST_INDEX = '1;
  localparam logic [tbd_pkg::RATE_W-1:0] RATE_MAX = '1;

  typedef struct packed {
    logic                       tone_present;
    logic [tbd_pkg::FREQ_W-1:0] measured_freq;
    logic                       freq_updated;
  } tone_reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_tone_present;
  logic [tbd_pkg::FREQ_W-1:0] out_measured_freq;
  logic out_freq_updated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tbd_pkg::IDX_W-1:0] cfg_index = tbd_pkg::REG_TICK_RATE;
  logic [tbd_pkg::RATE_W-1:0] cfg_wdata = '0;

  tone_band_detector_unit #(
    .PERIOD_BITS(PERIOD_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_level(in_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tone_present(out_tone_present),
    .out_measured_freq(out_measured_freq),
    .out_freq_updated(out_freq_updated),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // detector state mirrored in the testbench
  tbd_pkg::tbd_cfg_t det_cfg;
  logic det_prev_level;
  logic [PERIOD_BITS-1:0] det_elapsed;
  logic det_tone;
  logic [tbd_pkg::FREQ_W-1:0] det_freq;

  logic pending_levels[$];
  tone_reading_t tone_expected[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int stall_gap = 0;
  int queued_ticks = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int ticks_checked = 0;
  int edges_seen = 0;
  int tone_results = 0;
  int reg_writes = 0;
  int settings_used = 0;

  // one tick through the detector: period count, divide, band test, timeout
  function automatic tone_reading_t step_detector(input logic lvl);
    tone_reading_t r;
    logic rise;
    logic [PERIOD_BITS-1:0] cnt;
    logic [tbd_pkg::RATE_W-1:0] quo;
    int unsigned band, half, lo, hi;
    rise = lvl && !det_prev_level;
    cnt = det_elapsed;
    if (cnt != '1) begin
      cnt = cnt + 1'b1;
    end
    if (rise) begin
      quo = det_cfg.tick_rate_hz / cnt;
      det_freq = (quo > tbd_pkg::FREQ_MAX) ? tbd_pkg::FREQ_MAX : quo[tbd_pkg::FREQ_W-1:0];
      band = det_cfg.target_freq * det_cfg.band_percent / tbd_pkg::BAND_DIVISOR;
      half = band / 2;
      lo = (det_cfg.target_freq > half) ? det_cfg.target_freq - half : 0;
      hi = det_cfg.target_freq + half;
      if (hi > tbd_pkg::FREQ_MAX) begin
        hi = tbd_pkg::FREQ_MAX;
      end
      det_tone = (det_freq >= det_cfg.min_freq) && (det_freq >= lo) && (det_freq <= hi);
      det_elapsed = '0;
    end else begin
      det_elapsed = cnt;
      if (cnt >= det_cfg.timeout_ticks) begin
        det_tone = 1'b0;
      end
    end
    det_prev_level = lvl;
    r.tone_present = det_tone;
    r.measured_freq = det_freq;
    r.freq_updated = rise;
    return r;
  endfunction

  // mirror of a register write; unknown indexes are dropped
  function automatic void apply_reg(input logic [tbd_pkg::IDX_W-1:0] idx,
                                    input logic [tbd_pkg::RATE_W-1:0] data);
    case (idx)
      tbd_pkg::REG_TICK_RATE: det_cfg.tick_rate_hz = data;
      tbd_pkg::REG_TARGET: det_cfg.target_freq = data[tbd_pkg::FREQ_W-1:0];
      tbd_pkg::REG_BAND_PCT: det_cfg.band_percent = data[tbd_pkg::PCT_W-1:0];
      tbd_pkg::REG_MIN_FREQ: det_cfg.min_freq = data[tbd_pkg::FREQ_W-1:0];
      tbd_pkg::REG_TIMEOUT: det_cfg.timeout_ticks = data[tbd_pkg::TOUT_W-1:0];
      default: ;
    endcase
  endfunction

  // tick driver: one item per handshake, random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        tone_expected.push_back(step_detector(in_level));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_levels.size() > 0 && send_idle_pct > 0 &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 8) - 1;
          in_valid <= 1'b0;
        end else if (pending_levels.size() > 0) begin
          in_valid <= 1'b1;
          in_level <= pending_levels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tone_expected.size() == 0) begin
          $display("%0t: result with nothing expected: tone %0d freq %0d updated %0d",
                   $time, out_tone_present, out_measured_freq, out_freq_updated);
          mismatches++;
        end else begin
          tone_reading_t want;
          want = tone_expected.pop_front();
          ticks_checked++;
          if (want.freq_updated) edges_seen++;
          if (want.tone_present) tone_results++;
          if (out_tone_present !== want.tone_present) begin
            $display("%0t: tone_present expected %0d actual %0d",
                     $time, want.tone_present, out_tone_present);
            mismatches++;
          end
          if (out_measured_freq !== want.measured_freq) begin
            $display("%0t: measured_freq expected %0d actual %0d",
                     $time, want.measured_freq, out_measured_freq);
            mismatches++;
          end
          if (out_freq_updated !== want.freq_updated) begin
            $display("%0t: freq_updated expected %0d actual %0d",
                     $time, want.freq_updated, out_freq_updated);
            mismatches++;
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_gap = $urandom_range(1, 8) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("run stopped at cycle limit, %0d results still expected", tone_expected.size());
      $display("status: fail");
      $finish;
    end
  end

  // called right after a rising edge; returns right after one
  task automatic write_reg(input logic [tbd_pkg::IDX_W-1:0] idx,
                           input logic [tbd_pkg::RATE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic program_detector(input logic [tbd_pkg::RATE_W-1:0] rate,
                                  input logic [tbd_pkg::FREQ_W-1:0] target,
                                  input logic [tbd_pkg::PCT_W-1:0] pct,
                                  input logic [tbd_pkg::FREQ_W-1:0] min_f,
                                  input logic [tbd_pkg::TOUT_W-1:0] tout);
    write_reg(tbd_pkg::REG_TICK_RATE, rate);
    write_reg(tbd_pkg::REG_TARGET, tbd_pkg::RATE_W'(target));
    write_reg(tbd_pkg::REG_BAND_PCT, tbd_pkg::RATE_W'(pct));
    write_reg(tbd_pkg::REG_MIN_FREQ, tbd_pkg::RATE_W'(min_f));
    write_reg(tbd_pkg::REG_TIMEOUT, tbd_pkg::RATE_W'(tout));
    settings_used++;
  endtask

  // wait until every queued tick has come back, then let the block go quiet
  task automatic settle();
    do @(negedge clk);
    while (pending_levels.size() != 0 || in_valid || tone_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_run(input logic lvl, input int n);
    repeat (n) begin
      pending_levels.push_back(lvl);
      queued_ticks++;
    end
  endtask

  task automatic add_levels(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      add_run(bits[i], 1);
    end
  endtask

  // random settings around a nominal period, then mostly square waves near it
  task automatic random_phase(input int n_items);
    int p, per, hi_ticks, pick, start, reps;
    int unsigned max_tgt, rate;
    logic [tbd_pkg::FREQ_W-1:0] tgt, min_f;
    logic [tbd_pkg::PCT_W-1:0] pct;
    logic [tbd_pkg::TOUT_W-1:0] tout;
    p = $urandom_range(2, 48);
    max_tgt = RATE_MAX / p;
    if (max_tgt > tbd_pkg::FREQ_MAX) max_tgt = tbd_pkg::FREQ_MAX;
    tgt = tbd_pkg::FREQ_W'($urandom_range(1, max_tgt));
    rate = tgt * p + $urandom_range(0, p - 1);
    if (rate > RATE_MAX) rate = RATE_MAX;
    pct = ($urandom_range(0, 4) == 0) ? 7'd100 : 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 9);
    min_f = (pick == 0) ? '0 :
            (pick < 7) ? tbd_pkg::FREQ_W'($urandom_range(0, tgt)) :
            tbd_pkg::FREQ_W'($urandom);
    pick = $urandom_range(0, 9);
    tout = (pick == 0) ? '0 :
           (pick < 6) ? tbd_pkg::TOUT_W'($urandom_range(1, 3 * p)) :
           tbd_pkg::TOUT_W'($urandom_range(1, 65535));
    settle();
    // narrow registers get noise in the unused data bits
    write_reg(tbd_pkg::REG_TICK_RATE, tbd_pkg::RATE_W'(rate));
    write_reg(tbd_pkg::REG_TARGET, {8'($urandom), tgt});
    write_reg(tbd_pkg::REG_BAND_PCT, {17'($urandom), pct});
    write_reg(tbd_pkg::REG_MIN_FREQ, {8'($urandom), min_f});
    write_reg(tbd_pkg::REG_TIMEOUT, {8'($urandom), tout});
    if ($urandom_range(0, 2) == 0) begin
      write_reg(tbd_pkg::IDX_W'($urandom_range(tbd_pkg::REG_TIMEOUT + 1, REG_LAST_INDEX)),
                tbd_pkg::RATE_W'($urandom));
    end
    settings_used++;
    case ($urandom_range(0, 3))
      0: send_idle_pct = 0;
      1: send_idle_pct = 5;
      2: send_idle_pct = 20;
      default: send_idle_pct = 50;
    endcase
    case ($urandom_range(0, 3))
      0: recv_idle_pct = 0;
      1: recv_idle_pct = 5;
      2: recv_idle_pct = 20;
      default: recv_idle_pct = 50;
    endcase
    start = queued_ticks;
    while (queued_ticks - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        reps = $urandom_range(1, 6);
        repeat (reps) begin
          per = p + $urandom_range(0, 4) - 2;
          if (per < 2) per = 2;
          hi_ticks = $urandom_range(1, per - 1);
          add_run(1'b1, hi_ticks);
          add_run(1'b0, per - hi_ticks);
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 12)) add_run(1'($urandom), 1);
      end else begin
        // long quiet stretch to run into the timeout
        add_run(1'($urandom), $urandom_range(1, 120));
      end
    end
  endtask

  initial begin
    det_cfg.tick_rate_hz = tbd_pkg::RST_TICK_RATE;
    det_cfg.target_freq = tbd_pkg::RST_TARGET;
    det_cfg.band_percent = tbd_pkg::RST_BAND_PCT;
    det_cfg.min_freq = tbd_pkg::RST_MIN_FREQ;
    det_cfg.timeout_ticks = tbd_pkg::RST_TIMEOUT;
    det_prev_level = 1'b0;
    det_elapsed = '0;
    det_tone = 1'b0;
    det_freq = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: edge on the first tick, then two more rising edges
    send_idle_pct = 20;
    recv_idle_pct = 20;
    add_levels(32'b1101001, 7);

    // zero tick rate, widest band with upper clamp, timeout of zero
    settle();
    program_detector('0, tbd_pkg::FREQ_MAX, 7'd127, '0, '0);
    add_levels(32'b01011, 5);

    // band of zero width hit exactly, then a short timeout clears the flag
    settle();
    program_detector(24'd4000, 16'd1000, '0, 16'd1000, 16'd3);
    add_levels(32'b001110, 6);

    // saturated quotient against the top of the range
    settle();
    program_detector(RATE_MAX, 16'd1, '0, tbd_pkg::FREQ_MAX, tbd_pkg::TOUT_W'(1));
    add_levels(32'b0101, 4);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_phase(PHASE_TICKS);
    end

    // no idling from here on: long periods and the largest timeout
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_detector(RATE_MAX, tbd_pkg::FREQ_MAX, 7'd10, '0, '1);
    add_levels(32'b01, 2);
    add_run(1'b0, 120);
    add_run(1'b1, 1);
    add_levels(32'b01, 2);
    repeat (2) begin
      add_run(1'b0, 40);
      add_run(1'b1, 20);
    end

    settle();
    if (tone_expected.size() != 0) begin
      $display("%0d results never arrived", tone_expected.size());
      mismatches++;
    end
    $display("checked %0d ticks: %0d rising edges, %0d with tone present",
             ticks_checked, edges_seen, tone_results);
    $display("%0d register writes over %0d settings, ending with an idle-free stretch",
             reg_writes, settings_used);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
